[hw/rtl/hessian_binary_chunk_framer_assert.svh]
// assertion macros used by the framer's byte emitter
`ifndef HESSIAN_BINARY_CHUNK_FRAMER_ASSERT_SVH
`define HESSIAN_BINARY_CHUNK_FRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HBCF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HBCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hbcf_pkg.sv]
// package: constants, header byte codes and burst type of the binary framer
`timescale 1ns / 1ps

package hbcf_pkg;

    // chunk geometry
    localparam int unsigned CHUNK_W     = 16;
    localparam int unsigned CHUNK_BYTES = 32768;

    // header and marker byte codes
    localparam logic [7:0] CODE_CHUNK    = 8'h41;  // 'A', non-final chunk
    localparam logic [7:0] CODE_FINAL    = 8'h42;  // 'B', long final chunk
    localparam logic [7:0] CODE_NULL     = 8'h4E;  // 'N'
    localparam logic [7:0] CODE_SHORT    = 8'h20;  // short form base
    localparam logic [7:0] CODE_MEDIUM   = 8'h34;  // medium form base
    localparam logic [31:0] SHORT_MAX    = 32'd15;
    localparam logic [31:0] MEDIUM_MAX   = 32'd1023;

    localparam int unsigned BURST_MAX = 4;
    localparam int unsigned IDX_W     = $clog2(BURST_MAX);

    // bytes produced by one input item
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last_idx;
        logic                      msg_end;
    } burst_t;

endpackage

[hw/rtl/hbcf_encode.sv]
// combinational encoder: one input item and framing state to a burst of bytes
`timescale 1ns / 1ps

module hbcf_encode
    import hbcf_pkg::*;
(
    input  logic               start_flag,
    input  logic [31:0]        total_length,
    input  logic [7:0]         data_byte,
    input  logic [31:0]        remaining,
    input  logic [CHUNK_W-1:0] chunk_left,
    output logic               keep,
    output burst_t             burst,
    output logic [31:0]        remaining_next,
    output logic [CHUNK_W-1:0] chunk_left_next
);

    logic [31:0]        n;
    logic [CHUNK_W-1:0] cl_cur;
    logic [CHUNK_W-1:0] cl_open;
    logic [31:0]        n_dec;
    logic [IDX_W-1:0]   hdr_len;

    always_comb
    begin
        n               = start_flag ? total_length : remaining;
        cl_cur          = start_flag ? '0 : chunk_left;
        n_dec           = n - 32'd1;
        cl_open         = cl_cur;
        hdr_len         = '0;
        keep            = 1'b1;
        burst           = '0;
        remaining_next  = remaining;
        chunk_left_next = chunk_left;

        if (start_flag && (total_length == '0))
        begin
            // empty message encodes as null
            burst.bytes[0]  = CODE_NULL;
            burst.last_idx  = '0;
            burst.msg_end   = 1'b1;
            remaining_next  = '0;
            chunk_left_next = '0;
        end
        else if (!start_flag && (remaining == '0))
        begin
            // stray byte with no message open
            keep = 1'b0;
        end
        else
        begin
            // chunk header in front of the first byte of a chunk
            if (cl_cur == '0)
            begin
                if (n > 32'(CHUNK_BYTES))
                begin
                    burst.bytes[0] = CODE_CHUNK;
                    burst.bytes[1] = 8'((CHUNK_BYTES >> 8) & 32'hFF);
                    burst.bytes[2] = 8'(CHUNK_BYTES & 32'hFF);
                    hdr_len        = IDX_W'(3);
                    cl_open        = CHUNK_W'(CHUNK_BYTES);
                end
                else
                begin
                    if (n <= SHORT_MAX)
                    begin
                        burst.bytes[0] = CODE_SHORT + {4'b0, n[3:0]};
                        hdr_len        = IDX_W'(1);
                    end
                    else if (n <= MEDIUM_MAX)
                    begin
                        burst.bytes[0] = CODE_MEDIUM + {6'b0, n[9:8]};
                        burst.bytes[1] = n[7:0];
                        hdr_len        = IDX_W'(2);
                    end
                    else
                    begin
                        burst.bytes[0] = CODE_FINAL;
                        burst.bytes[1] = n[15:8];
                        burst.bytes[2] = n[7:0];
                        hdr_len        = IDX_W'(3);
                    end
                    cl_open = n[CHUNK_W-1:0];
                end
            end

            // payload byte after the header
            burst.bytes[hdr_len] = data_byte;
            burst.last_idx       = hdr_len;
            burst.msg_end        = (n_dec == '0);
            remaining_next       = n_dec;
            chunk_left_next      = (n_dec == '0) ? '0 : CHUNK_W'(cl_open - CHUNK_W'(1));
        end
    end

endmodule

[hw/rtl/hbcf_emit.sv]
// result register: holds one burst and sends its bytes one per transfer
`timescale 1ns / 1ps

`include "hessian_binary_chunk_framer_assert.svh"

module hbcf_emit
    import hbcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  burst_t     burst,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // message_end
);

    logic             valid_reg;
    logic             valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    burst_t           burst_reg;
    logic             at_last;
    logic             xfer;

    // position in the burst
    assign at_last = (idx_reg == burst_reg.last_idx);
    assign xfer    = valid_reg && m_tready;
    assign free    = !valid_reg || (xfer && at_last);

    // next burst state
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (xfer)
        begin
            if (at_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

    // output fields
    assign m_tvalid = valid_reg;
    assign m_tdata  = burst_reg.bytes[idx_reg];
    assign m_tlast  = at_last;
    assign m_tuser  = at_last && burst_reg.msg_end;

    `HBCF_ASSERT_IMPL(a_load_when_free, load, free, "burst loaded over unsent bytes")
    `HBCF_ASSERT_IMPL(a_idx_in_burst, valid_reg, idx_reg <= burst_reg.last_idx,
        "byte index past end of burst")
    `HBCF_ASSERT_NEXT(a_drain_empties, xfer && at_last && !load, !valid_reg,
        "burst still valid after its last transfer")
    `HBCF_ASSERT_NEXT(a_load_starts, load, valid_reg && (idx_reg == '0),
        "new burst does not start at its first byte")

endmodule

[hw/rtl/hessian_binary_chunk_framer.sv]
// top level: Hessian2 binary chunk framer with input register and byte emitter
`timescale 1ns / 1ps
//
// Usage
//   Input channel s_*: one item per transfer. s_tuser is the start flag; on a
//   start item s_tdata[31:0] gives the message length, s_tdata[39:32] is the
//   payload byte. Every later item carries one payload byte.
//   Output channel m_*: one encoded byte per transfer (chunk header or payload);
//   m_tlast marks the last byte caused by one input item, m_tuser the final
//   byte of the encoded message. An empty message gives the single byte 'N'.
// Flow
//   An accepted item is held in the input register, then loaded into the
//   byte emitter's burst register, which drives its first byte on m_tdata.
//   The first byte of a chunk follows its header bytes (one to three), each
//   sent as a transfer of its own. The byte emitter sets the pace: an item
//   leaves the input register when the emitter is empty or the previous
//   burst sends its last byte; a new item can wait there meanwhile.
// Reset and stall
//   Reset closes any open message and empties both registers. When m_tready
//   is low the current byte holds and s_tready falls once the input register
//   is full; a start item while a message is open abandons that message.
//

module hessian_binary_chunk_framer
    import hbcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // total_length[31:0], data_byte[39:32]
    input  logic        s_tuser,   // start_flag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // message_end
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic               start_reg;
    logic [31:0]        length_reg;
    logic [7:0]         byte_reg;
    logic [31:0]        remaining_reg;
    logic [31:0]        remaining_next;
    logic [CHUNK_W-1:0] chunk_left_reg;
    logic [CHUNK_W-1:0] chunk_left_next;
    logic               keep;
    burst_t             burst;
    logic               free;
    logic               in_move;
    logic               s_xfer;

    // input register handshake
    assign in_move  = in_valid_reg && free;
    assign s_tready = !in_valid_reg || in_move;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_move)
        begin
            in_valid_next = 1'b0;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            start_reg  <= s_tuser;
            length_reg <= s_tdata[31:0];
            byte_reg   <= s_tdata[39:32];
        end
    end

    // control and framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            remaining_reg  <= '0;
            chunk_left_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (in_move)
            begin
                remaining_reg  <= remaining_next;
                chunk_left_reg <= chunk_left_next;
            end
        end
    end

    // header and payload selection
    hbcf_encode u_encode (
        .start_flag      (start_reg),
        .total_length    (length_reg),
        .data_byte       (byte_reg),
        .remaining       (remaining_reg),
        .chunk_left      (chunk_left_reg),
        .keep            (keep),
        .burst           (burst),
        .remaining_next  (remaining_next),
        .chunk_left_next (chunk_left_next)
    );

    // byte emitter
    hbcf_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_move && keep),
        .burst    (burst),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
